>>> hw/rtl/ppmd_pkg.sv
`default_nettype none

package ppmd_pkg;

    // Width of the reported distance word
    localparam int OUT_WIDTH = 17;

    // Widest coordinate that the exact arithmetic handles
    localparam int COORD_MAX = 31;

    // Polygon marks carried with each vertex
    typedef struct packed {
        logic first;
        logic last;
    } mark_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppmd_front.sv
`default_nettype none

module ppmd_front #(
    parameter int COORD_BITS = 16,
    localparam int JW = 8 * COORD_BITS + 2
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [COORD_BITS-1:0] in_query_x,
    input  wire logic [COORD_BITS-1:0] in_query_y,
    input  wire logic [COORD_BITS-1:0] in_corner_x,
    input  wire logic [COORD_BITS-1:0] in_corner_y,
    input  wire logic                  in_first,
    input  wire logic                  in_last,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       job_valid,
    input  wire logic                  job_ready,
    output logic [JW-1:0]              job_data
);

    logic [COORD_BITS-1:0] pt_x_reg, pt_y_reg;
    logic [COORD_BITS-1:0] start_x_reg, start_y_reg;
    logic [COORD_BITS-1:0] prior_x_reg, prior_y_reg;
    logic [COORD_BITS-1:0] pt_x_next, pt_y_next;
    logic [COORD_BITS-1:0] start_x_next, start_y_next;
    ppmd_pkg::mark_t       mark;
    logic                  take_word;

    assign mark.first = in_first;
    assign mark.last  = in_last;

    // Pass the handshake straight to the job queue
    assign job_valid = in_valid;
    assign in_ready  = job_ready;
    assign take_word = in_valid && job_ready;

    // Pick the point and start vertex this word works with
    assign pt_x_next    = in_first ? in_query_x  : pt_x_reg;
    assign pt_y_next    = in_first ? in_query_y  : pt_y_reg;
    assign start_x_next = in_first ? in_corner_x : start_x_reg;
    assign start_y_next = in_first ? in_corner_y : start_y_reg;

    // Build the job: point, previous vertex, this vertex, start vertex, marks
    assign job_data = {pt_x_next, pt_y_next, prior_x_reg, prior_y_reg,
                       in_corner_x, in_corner_y, start_x_next, start_y_next, mark};

    // Hold polygon context across words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_x_reg    <= '0;
            pt_y_reg    <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prior_x_reg <= '0;
            prior_y_reg <= '0;
        end else if (take_word) begin
            pt_x_reg    <= pt_x_next;
            pt_y_reg    <= pt_y_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            prior_x_reg <= in_corner_x;
            prior_y_reg <= in_corner_y;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppmd_queue.sv
`default_nettype none

module ppmd_queue #(
    parameter int WIDTH = 130
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store incoming words
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppmd_isqrt.sv
`default_nettype none

module ppmd_isqrt #(
    parameter int COORD_BITS = 16,
    localparam int BB = 2 * COORD_BITS + 2,
    localparam int RW = COORD_BITS + 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [BB-1:0] value,
    output logic               busy,
    output logic [RW-1:0]      root
);

    localparam int NW = $clog2(RW + 1);

    logic          busy_reg;
    logic [NW-1:0] cnt_reg;
    logic [BB-1:0] val_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [RW+3:0] rem_shift, trial, rem_diff;
    logic          fits;

    assign busy = busy_reg;
    assign root = root_reg;

    // Bring down two bits and try the next root digit
    assign rem_shift = {rem_reg, val_reg[BB-1:BB-2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;
    assign fits      = (rem_shift >= trial);

    // Step one root bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start && !busy_reg) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == NW'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= NW'(RW);
        end else if (busy_reg) begin
            val_reg  <= {val_reg[BB-3:0], 2'b00};
            rem_reg  <= fits ? rem_diff[RW+1:0] : rem_shift[RW+1:0];
            root_reg <= {root_reg[RW-2:0], fits};
            cnt_reg  <= cnt_reg - NW'(1);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppmd_back.sv
`default_nettype none

module ppmd_back #(
    parameter int COORD_BITS = 16,
    localparam int JW = 8 * COORD_BITS + 2
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            job_valid,
    output logic                                 job_ready,
    input  wire logic [JW-1:0]                   job_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [ppmd_pkg::OUT_WIDTH-1:0]       m_min_distance
);

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int AW  = PW + 1;
    localparam int BB  = 2 * CW + 2;
    localparam int RW  = CW + 1;
    localparam int OW  = ppmd_pkg::OUT_WIDTH;
    localparam int BCW = $clog2(BB);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SETUP  = 10'b00_0000_0010,
        S_MUL    = 10'b00_0000_0100,
        S_DECIDE = 10'b00_0000_1000,
        S_DIV    = 10'b00_0001_0000,
        S_FIX    = 10'b00_0010_0000,
        S_TAKE   = 10'b00_0100_0000,
        S_ROOT   = 10'b00_1000_0000,
        S_HOLD   = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [JW-1:0]          job_reg;
    logic                   phase_reg;
    logic [3:0]             step_reg;
    logic [BCW-1:0]         bit_reg;
    logic signed [DW-1:0]   wx_reg, wy_reg, vx_reg, vy_reg, ux_reg, uy_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   w2_reg, c1_reg, c2_reg, u2_reg;
    logic [BB-1:0]          rem_reg, quo_reg, cand_reg, best_reg;
    logic                   m_valid_reg;
    logic [OW-1:0]          out_reg;

    logic [CW-1:0]          px, py, ox, oy, cx, cy, sx, sy;
    ppmd_pkg::mark_t        mark, in_mark;
    logic [CW-1:0]          x0, y0, x1, y1;
    logic signed [DW-1:0]   op_a, op_b;
    logic signed [AW-1:0]   prod_ext;
    logic [3:0]             acc_idx;
    logic [BB-1:0]          c1_lo;
    logic [BB+1:0]          div_t, c2_one, c2_two;
    logic [BB-1:0]          rem_next;
    logic [1:0]             quo_inc;
    logic                   c1_nonpos, end_closer;
    logic                   root_start, root_busy;
    logic [RW-1:0]          root;
    logic [RW+OW-1:0]       root_ext;
    logic                   out_free;

    // Unpack the current job
    assign {px, py, ox, oy, cx, cy, sx, sy, mark} = job_reg;
    assign in_mark = ppmd_pkg::mark_t'(job_data[1:0]);

    // Select the edge: previous-to-this, then this-to-start
    assign x0 = phase_reg ? cx : ox;
    assign y0 = phase_reg ? cy : oy;
    assign x1 = phase_reg ? sx : cx;
    assign y1 = phase_reg ? sy : cy;

    // Feed the shared multiplier by step
    always_comb begin
        case (step_reg[2:0])
            3'd0: begin op_a = wx_reg; op_b = wx_reg; end
            3'd1: begin op_a = wy_reg; op_b = wy_reg; end
            3'd2: begin op_a = wx_reg; op_b = vx_reg; end
            3'd3: begin op_a = wy_reg; op_b = vy_reg; end
            3'd4: begin op_a = vx_reg; op_b = vx_reg; end
            3'd5: begin op_a = vy_reg; op_b = vy_reg; end
            3'd6: begin op_a = ux_reg; op_b = ux_reg; end
            default: begin op_a = uy_reg; op_b = uy_reg; end
        endcase
    end

    assign prod_ext = {prod_reg[PW-1], prod_reg};
    assign acc_idx  = step_reg - 4'd1;

    // Decide the edge case from the projection
    assign c1_nonpos = c1_reg[AW-1] || (c1_reg == '0);
    assign end_closer = (c2_reg <= c1_reg);

    // One quotient bit of floor(c1*c1/c2) per cycle, c1 taken MSB first
    assign c1_lo  = c1_reg[BB-1:0];
    assign c2_one = {2'b00, c2_reg[BB-1:0]};
    assign c2_two = {1'b0, c2_reg[BB-1:0], 1'b0};
    assign div_t  = {1'b0, rem_reg, 1'b0} + (c1_lo[bit_reg] ? {2'b00, c1_lo} : '0);

    always_comb begin
        if (div_t >= c2_two) begin
            rem_next = BB'(div_t - c2_two);
            quo_inc  = 2'd2;
        end else if (div_t >= c2_one) begin
            rem_next = BB'(div_t - c2_one);
            quo_inc  = 2'd1;
        end else begin
            rem_next = div_t[BB-1:0];
            quo_inc  = 2'd0;
        end
    end

    assign job_ready  = (state_reg == S_IDLE);
    assign root_start = (state_reg == S_ROOT);
    assign out_free   = !m_valid_reg || m_ready;
    assign root_ext   = {{OW{1'b0}}, root};

    // Sequence one job
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    if (!in_mark.first || in_mark.last) begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:  state_next = S_MUL;
            S_MUL: begin
                if (step_reg == 4'd8) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = (c1_nonpos || end_closer) ? S_TAKE : S_DIV;
            S_DIV: begin
                if (bit_reg == '0) begin
                    state_next = S_FIX;
                end
            end
            S_FIX:    state_next = S_TAKE;
            S_TAKE: begin
                if (!phase_reg && mark.last) begin
                    state_next = S_SETUP;
                end else if (mark.last) begin
                    state_next = S_ROOT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT:   state_next = S_HOLD;
            S_HOLD: begin
                if (!root_busy) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Advance control state, running minimum and output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            best_reg    <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && job_valid && in_mark.first) begin
                best_reg <= '1;
            end else if (state_reg == S_TAKE && cand_reg < best_reg) begin
                best_reg <= cand_reg;
            end
            if (state_reg == S_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    job_reg   <= job_data;
                    phase_reg <= in_mark.first;
                end
            end
            S_SETUP: begin
                vx_reg   <= $signed({x1[CW-1], x1}) - $signed({x0[CW-1], x0});
                vy_reg   <= $signed({y1[CW-1], y1}) - $signed({y0[CW-1], y0});
                wx_reg   <= $signed({px[CW-1], px}) - $signed({x0[CW-1], x0});
                wy_reg   <= $signed({py[CW-1], py}) - $signed({y0[CW-1], y0});
                ux_reg   <= $signed({px[CW-1], px}) - $signed({x1[CW-1], x1});
                uy_reg   <= $signed({py[CW-1], py}) - $signed({y1[CW-1], y1});
                step_reg <= 4'd0;
            end
            S_MUL: begin
                prod_reg <= op_a * op_b;
                step_reg <= step_reg + 4'd1;
                if (step_reg != 4'd0) begin
                    case (acc_idx[2:1])
                        2'd0: w2_reg <= acc_idx[0] ? w2_reg + prod_ext : prod_ext;
                        2'd1: c1_reg <= acc_idx[0] ? c1_reg + prod_ext : prod_ext;
                        2'd2: c2_reg <= acc_idx[0] ? c2_reg + prod_ext : prod_ext;
                        default: u2_reg <= acc_idx[0] ? u2_reg + prod_ext : prod_ext;
                    endcase
                end
            end
            S_DECIDE: begin
                cand_reg <= c1_nonpos ? w2_reg[BB-1:0] : u2_reg[BB-1:0];
                rem_reg  <= '0;
                quo_reg  <= '0;
                bit_reg  <= BCW'(BB - 1);
            end
            S_DIV: begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[BB-2:0], 1'b0} + BB'(quo_inc);
                bit_reg <= bit_reg - BCW'(1);
            end
            S_FIX: begin
                cand_reg <= w2_reg[BB-1:0] - quo_reg;
            end
            S_TAKE: begin
                phase_reg <= 1'b1;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_reg <= root_ext[OW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    ppmd_isqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .value   (best_reg),
        .busy    (root_busy),
        .root    (root)
    );

    assign m_valid        = m_valid_reg;
    assign m_min_distance = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/point_polygon_min_distance.sv
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   query point, vertex, first/last marks
// m_        out        m_valid / m_ready   floor of least boundary distance (unsigned integer)
//
// An edge runs through the setup, multiply and decide states and is taken
// at once when an endpoint is nearest; when the projection falls inside, the
// bit-serial quotient loop and a fix step come before it is taken. A closing
// vertex runs both of its edges, then the square root of the least squared distance.
// Reset is synchronous and active low; the two-entry job queue lets the input
// side take up to two words while the back unit or the output stalls.
`default_nettype none

module point_polygon_min_distance #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [COORD_WIDTH-1:0]         s_query_x,
    input  wire logic [COORD_WIDTH-1:0]         s_query_y,
    input  wire logic [COORD_WIDTH-1:0]         s_corner_x,
    input  wire logic [COORD_WIDTH-1:0]         s_corner_y,
    input  wire logic                           s_first_corner,
    input  wire logic                           s_last_corner,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    output logic [ppmd_pkg::OUT_WIDTH-1:0]      m_min_distance,
    output logic                                m_valid,
    input  wire logic                           m_ready
);

    localparam int CW = (COORD_WIDTH > ppmd_pkg::COORD_MAX) ?
                        ppmd_pkg::COORD_MAX : COORD_WIDTH;
    localparam int JW = 8 * CW + 2;

    logic          push_valid, push_ready;
    logic [JW-1:0] push_data;
    logic          pop_valid, pop_ready;
    logic [JW-1:0] pop_data;

    // Accept and tag vertices
    ppmd_front #(
        .COORD_BITS (CW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_query_x  (s_query_x[CW-1:0]),
        .in_query_y  (s_query_y[CW-1:0]),
        .in_corner_x (s_corner_x[CW-1:0]),
        .in_corner_y (s_corner_y[CW-1:0]),
        .in_first    (s_first_corner),
        .in_last     (s_last_corner),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .job_valid   (push_valid),
        .job_ready   (push_ready),
        .job_data    (push_data)
    );

    // Buffer jobs between front and back
    ppmd_queue #(
        .WIDTH (JW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Measure edges, keep the minimum, emit the root
    ppmd_back #(
        .COORD_BITS (CW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (pop_valid),
        .job_ready      (pop_ready),
        .job_data       (pop_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_min_distance (m_min_distance)
    );

endmodule

`default_nettype wire
